[design/tlbpt_pkg.sv]
// shared types and constants for the page table translator
`timescale 1ns / 1ps

package tlbpt_pkg;

    localparam int PAGE_W      = 8;
    localparam int OFFSET_W    = 8;
    localparam int FRAME_W     = 7;
    localparam int VADDR_W     = PAGE_W + OFFSET_W;
    localparam int PADDR_W     = FRAME_W + OFFSET_W;
    localparam int LOAD_W      = 16;
    localparam int TLB_CNT_W   = 32;
    localparam int MAP_CNT_W   = 9;
    localparam int IDX_W       = 9;

    localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } t_entry;

endpackage

[design/tlbpt_spram.sv]
// single-port synchronous ram with registered read data
`timescale 1ns / 1ps

module tlbpt_spram
    import tlbpt_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 15
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic                     i_we,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/tlb_page_table_translator.sv]
// top level: tlb and page table lookup, frame allocation and eviction sequencer
// Each address is handled one at a time by a sequencer around three single-port
// memories (tlb, page table, frame load counts); every memory access has a read
// state to issue it and a check state to test the registered data. A tlb hit ends
// the search at the matching entry; a page table hit comes after a full tlb scan
// and a table scan up to the match. A fault while frames are still unused follows
// the two full scans; once all frames are in use it adds a scan of every frame's
// load count and an eviction pass over the page table and tlb entries. The input
// stalls while an address is in work; a finished result waits in the output register
// and the next address can be taken meanwhile.
`timescale 1ns / 1ps

module tlb_page_table_translator
    import tlbpt_pkg::*;
#(
    parameter int FRAME_COUNT = 128,
    parameter int TLB_ENTRIES = 16,
    parameter int MAP_ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [VADDR_W-1:0] i_virtual_address,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [PADDR_W-1:0] o_physical_address,
    output logic               o_tlb_hit,
    output logic               o_page_fault
);

    localparam int TA_W = $clog2(TLB_ENTRIES);
    localparam int MA_W = $clog2(MAP_ENTRIES);
    localparam int FA_W = $clog2(FRAME_COUNT);
    localparam int CL_W = $clog2(FRAME_COUNT + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_TLB_RD  = 4'd1;
    localparam logic [3:0] S_TLB_CHK = 4'd2;
    localparam logic [3:0] S_MAP_RD  = 4'd3;
    localparam logic [3:0] S_MAP_CHK = 4'd4;
    localparam logic [3:0] S_PICK    = 4'd5;
    localparam logic [3:0] S_LD_RD   = 4'd6;
    localparam logic [3:0] S_LD_CHK  = 4'd7;
    localparam logic [3:0] S_EVM_RD  = 4'd8;
    localparam logic [3:0] S_EVM_CHK = 4'd9;
    localparam logic [3:0] S_EVM_CP  = 4'd10;
    localparam logic [3:0] S_EVT_RD  = 4'd11;
    localparam logic [3:0] S_EVT_CHK = 4'd12;
    localparam logic [3:0] S_EVT_CP  = 4'd13;
    localparam logic [3:0] S_APPEND  = 4'd14;
    localparam logic [3:0] S_DONE    = 4'd15;

    // control state
    logic [3:0]           r_state, n_state;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [TLB_CNT_W-1:0] r_tlb_cnt, n_tlb_cnt;
    logic [TA_W-1:0]      r_tlb_ptr, n_tlb_ptr;
    logic [MAP_CNT_W-1:0] r_map_cnt, n_map_cnt;
    logic [MA_W-1:0]      r_map_ptr, n_map_ptr;
    logic [CL_W-1:0]      r_claim_cnt, n_claim_cnt;
    logic                 r_out_valid, n_out_valid;

    // item payload
    logic [PAGE_W-1:0]    r_page, n_page;
    logic [OFFSET_W-1:0]  r_offset, n_offset;
    logic [FRAME_W-1:0]   r_frame, n_frame;
    logic                 r_hit, n_hit;
    logic                 r_fault, n_fault;
    logic                 r_evict, n_evict;
    logic [LOAD_W-1:0]    r_least, n_least;
    logic [IDX_W-1:0]     r_tlb_lim, n_tlb_lim;
    logic [IDX_W-1:0]     r_map_lim, n_map_lim;
    logic [FRAME_W-1:0]   r_out_frame, n_out_frame;
    logic [OFFSET_W-1:0]  r_out_offset, n_out_offset;
    logic                 r_out_hit, n_out_hit;
    logic                 r_out_fault, n_out_fault;

    // memory ports
    logic [TA_W-1:0]   tlb_addr;
    logic              tlb_we;
    t_entry            tlb_wdata, tlb_rdata;
    logic [MA_W-1:0]   map_addr;
    logic              map_we;
    t_entry            map_wdata, map_rdata;
    logic [FA_W-1:0]   ld_addr;
    logic              ld_we;
    logic [LOAD_W-1:0] ld_wdata, ld_rdata;

    logic              in_xfer;
    logic [TA_W-1:0]   tlb_ptr_dec, tlb_ptr_inc;
    logic [MA_W-1:0]   map_ptr_dec, map_ptr_inc;

    tlbpt_spram #(.DEPTH(TLB_ENTRIES), .WIDTH($bits(t_entry))) u_tlb_ram (
        .i_clk   (i_clk),
        .i_addr  (tlb_addr),
        .i_we    (tlb_we),
        .i_wdata (tlb_wdata),
        .o_rdata (tlb_rdata)
    );

    tlbpt_spram #(.DEPTH(MAP_ENTRIES), .WIDTH($bits(t_entry))) u_map_ram (
        .i_clk   (i_clk),
        .i_addr  (map_addr),
        .i_we    (map_we),
        .i_wdata (map_wdata),
        .o_rdata (map_rdata)
    );

    tlbpt_spram #(.DEPTH(FRAME_COUNT), .WIDTH(LOAD_W)) u_load_ram (
        .i_clk   (i_clk),
        .i_addr  (ld_addr),
        .i_we    (ld_we),
        .i_wdata (ld_wdata),
        .o_rdata (ld_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;

    // pointers track count mod size, including the wrap of the count itself
    assign tlb_ptr_dec = (r_tlb_ptr == '0) ? TA_W'(TLB_ENTRIES - 1) : r_tlb_ptr - 1'b1;
    assign map_ptr_dec = (r_map_ptr == '0) ? MA_W'(MAP_ENTRIES - 1) : r_map_ptr - 1'b1;
    assign tlb_ptr_inc = (r_tlb_cnt == '1 || r_tlb_ptr == TA_W'(TLB_ENTRIES - 1))
                         ? '0 : r_tlb_ptr + 1'b1;
    assign map_ptr_inc = (r_map_cnt == '1 || r_map_ptr == MA_W'(MAP_ENTRIES - 1))
                         ? '0 : r_map_ptr + 1'b1;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_tlb_cnt    = r_tlb_cnt;
        n_tlb_ptr    = r_tlb_ptr;
        n_map_cnt    = r_map_cnt;
        n_map_ptr    = r_map_ptr;
        n_claim_cnt  = r_claim_cnt;
        n_out_valid  = r_out_valid;
        n_page       = r_page;
        n_offset     = r_offset;
        n_frame      = r_frame;
        n_hit        = r_hit;
        n_fault      = r_fault;
        n_evict      = r_evict;
        n_least      = r_least;
        n_tlb_lim    = r_tlb_lim;
        n_map_lim    = r_map_lim;
        n_out_frame  = r_out_frame;
        n_out_offset = r_out_offset;
        n_out_hit    = r_out_hit;
        n_out_fault  = r_out_fault;

        tlb_addr  = r_idx[TA_W-1:0];
        tlb_we    = 1'b0;
        tlb_wdata = tlb_rdata;
        map_addr  = r_idx[MA_W-1:0];
        map_we    = 1'b0;
        map_wdata = map_rdata;
        ld_addr   = r_idx[FA_W-1:0];
        ld_we     = 1'b0;
        ld_wdata  = ld_rdata;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_page    = i_virtual_address[VADDR_W-1:OFFSET_W];
                    n_offset  = i_virtual_address[OFFSET_W-1:0];
                    n_hit     = 1'b0;
                    n_fault   = 1'b0;
                    n_evict   = 1'b0;
                    n_idx     = '0;
                    n_tlb_lim = (r_tlb_cnt < TLB_CNT_W'(TLB_ENTRIES))
                                ? r_tlb_cnt[IDX_W-1:0] : IDX_W'(TLB_ENTRIES);
                    n_map_lim = (r_map_cnt < MAP_CNT_W'(MAP_ENTRIES))
                                ? r_map_cnt : IDX_W'(MAP_ENTRIES);
                    n_state   = S_TLB_RD;
                end
            end
            S_TLB_RD: begin
                if (r_idx < r_tlb_lim) begin
                    n_state = S_TLB_CHK;
                end else begin
                    n_idx   = '0;
                    n_state = S_MAP_RD;
                end
            end
            S_TLB_CHK: begin
                if (tlb_rdata.page == r_page) begin
                    n_frame = tlb_rdata.frame;
                    n_hit   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_TLB_RD;
                end
            end
            S_MAP_RD: begin
                n_state = (r_idx < r_map_lim) ? S_MAP_CHK : S_PICK;
            end
            S_MAP_CHK: begin
                if (map_rdata.page == r_page) begin
                    n_frame = map_rdata.frame;
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_MAP_RD;
                end
            end
            S_PICK: begin
                n_fault = 1'b1;
                // frames are claimed in order and never released
                if (r_claim_cnt < CL_W'(FRAME_COUNT)) begin
                    n_frame     = FRAME_W'(r_claim_cnt);
                    n_claim_cnt = r_claim_cnt + 1'b1;
                    n_state     = S_APPEND;
                end else begin
                    n_evict = 1'b1;
                    n_idx   = '0;
                    n_state = S_LD_RD;
                end
            end
            S_LD_RD: begin
                if (r_idx < IDX_W'(FRAME_COUNT)) begin
                    n_state = S_LD_CHK;
                end else begin
                    n_idx   = '0;
                    n_state = S_EVM_RD;
                end
            end
            S_LD_CHK: begin
                // ties go to the higher frame
                if (r_idx == '0 || ld_rdata <= r_least) begin
                    n_least = ld_rdata;
                    n_frame = FRAME_W'(r_idx);
                end
                n_idx   = r_idx + 1'b1;
                n_state = S_LD_RD;
            end
            S_EVM_RD: begin
                if (r_idx < r_map_lim) begin
                    n_state = S_EVM_CHK;
                end else begin
                    n_idx   = '0;
                    n_state = S_EVT_RD;
                end
            end
            S_EVM_CHK: begin
                if (map_rdata.frame == r_frame && r_map_cnt != '0) begin
                    map_addr = map_ptr_dec;
                    n_state  = S_EVM_CP;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_EVM_RD;
                end
            end
            S_EVM_CP: begin
                // move the last entry into the removed slot
                map_we    = 1'b1;
                map_wdata = map_rdata;
                n_map_cnt = r_map_cnt - 1'b1;
                n_map_ptr = map_ptr_dec;
                n_idx     = r_idx + 1'b1;
                n_state   = S_EVM_RD;
            end
            S_EVT_RD: begin
                n_state = (r_idx < r_tlb_lim) ? S_EVT_CHK : S_APPEND;
            end
            S_EVT_CHK: begin
                if (tlb_rdata.frame == r_frame && r_tlb_cnt != '0) begin
                    tlb_addr = tlb_ptr_dec;
                    n_state  = S_EVT_CP;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_EVT_RD;
                end
            end
            S_EVT_CP: begin
                tlb_we    = 1'b1;
                tlb_wdata = tlb_rdata;
                n_tlb_cnt = r_tlb_cnt - 1'b1;
                n_tlb_ptr = tlb_ptr_dec;
                n_idx     = r_idx + 1'b1;
                n_state   = S_EVT_RD;
            end
            S_APPEND: begin
                map_we          = 1'b1;
                map_addr        = r_map_ptr;
                map_wdata.page  = r_page;
                map_wdata.frame = r_frame;
                n_map_cnt       = r_map_cnt + 1'b1;
                n_map_ptr       = map_ptr_inc;
                tlb_we          = 1'b1;
                tlb_addr        = r_tlb_ptr;
                tlb_wdata.page  = r_page;
                tlb_wdata.frame = r_frame;
                n_tlb_cnt       = r_tlb_cnt + 1'b1;
                n_tlb_ptr       = tlb_ptr_inc;
                ld_we           = 1'b1;
                ld_addr         = r_frame[FA_W-1:0];
                if (!r_evict) begin
                    ld_wdata = LOAD_W'(1);
                end else if (r_least == LOAD_MAX) begin
                    ld_wdata = r_least;
                end else begin
                    ld_wdata = r_least + 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_frame  = r_frame;
                    n_out_offset = r_offset;
                    n_out_hit    = r_hit;
                    n_out_fault  = r_fault;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_tlb_cnt   <= '0;
            r_tlb_ptr   <= '0;
            r_map_cnt   <= '0;
            r_map_ptr   <= '0;
            r_claim_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_tlb_cnt   <= n_tlb_cnt;
            r_tlb_ptr   <= n_tlb_ptr;
            r_map_cnt   <= n_map_cnt;
            r_map_ptr   <= n_map_ptr;
            r_claim_cnt <= n_claim_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page       <= n_page;
        r_offset     <= n_offset;
        r_frame      <= n_frame;
        r_hit        <= n_hit;
        r_fault      <= n_fault;
        r_evict      <= n_evict;
        r_least      <= n_least;
        r_tlb_lim    <= n_tlb_lim;
        r_map_lim    <= n_map_lim;
        r_out_frame  <= n_out_frame;
        r_out_offset <= n_out_offset;
        r_out_hit    <= n_out_hit;
        r_out_fault  <= n_out_fault;
    end

    assign o_out_valid        = r_out_valid;
    assign o_physical_address = {r_out_frame, r_out_offset};
    assign o_tlb_hit          = r_out_hit;
    assign o_page_fault       = r_out_fault;

`ifndef SYNTHESIS
    a_claim_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_claim_cnt <= CL_W'(FRAME_COUNT))
        else $error("claim counter beyond frame count");

    a_hit_not_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_tlb_hit && o_page_fault))
        else $error("result flagged as both tlb hit and fault");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_state == S_TLB_RD)
        else $error("accepted address did not start the tlb search");

    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LD_RD |-> r_claim_cnt == CL_W'(FRAME_COUNT))
        else $error("eviction scan while frames remain unclaimed");
`endif

endmodule

[test/tb.sv]
// self-checking testbench for the tlb and page table address translator
`timescale 1ns / 1ps

class xlate_scoreboard;
    // predicted translator state
    logic [7:0]  tlb_tag[16];
    logic [6:0]  tlb_frame[16];
    int unsigned tlb_count;
    logic [7:0]  map_tag[256];
    logic [6:0]  map_frame[256];
    int unsigned map_count;
    bit          claimed[128];
    int unsigned loads[128];
    // expected result fields, oldest first
    logic [14:0] exp_paddr[$];
    bit          exp_hit[$];
    bit          exp_fault[$];
    int          errors;
    int          n_hit, n_walk, n_fault, n_evict;

    function void clear_state();
        tlb_count = 0;
        map_count = 0;
        foreach (claimed[i]) begin
            claimed[i] = 0;
            loads[i] = 0;
        end
    endfunction

    function void drop_frame(logic [6:0] victim, int unsigned map_lim, int unsigned tlb_lim);
        int unsigned last;
        for (int unsigned x = 0; x < map_lim; x++) begin
            if (map_frame[x] == victim && map_count != 0) begin
                last = (map_count - 1) % 256;
                map_tag[x] = map_tag[last];
                map_frame[x] = map_frame[last];
                map_count = (map_count - 1) & 9'h1ff;
            end
        end
        for (int unsigned x = 0; x < tlb_lim; x++) begin
            if (tlb_frame[x] == victim && tlb_count != 0) begin
                last = (tlb_count - 1) % 16;
                tlb_tag[x] = tlb_tag[last];
                tlb_frame[x] = tlb_frame[last];
                tlb_count = tlb_count - 1;
            end
        end
    endfunction

    // work out the translation of one accepted address
    function void note_address(logic [15:0] va);
        logic [7:0]  page;
        logic [6:0]  frame;
        int unsigned tlb_lim, map_lim, least, victim;
        bit          found, hit, fault, full;
        page = va[15:8];
        tlb_lim = (tlb_count < 16) ? tlb_count : 16;
        map_lim = (map_count < 256) ? map_count : 256;
        found = 0; hit = 0; fault = 0; frame = '0;
        for (int unsigned x = 0; x < tlb_lim && !found; x++) begin
            if (tlb_tag[x] == page) begin
                frame = tlb_frame[x];
                found = 1;
                hit = 1;
            end
        end
        for (int unsigned x = 0; x < map_lim && !found; x++) begin
            if (map_tag[x] == page) begin
                frame = map_frame[x];
                found = 1;
            end
        end
        if (!found) begin
            full = 1;
            for (int x = 0; x < 128 && full; x++) begin
                if (!claimed[x]) begin
                    claimed[x] = 1;
                    frame = 7'(x);
                    full = 0;
                end
            end
            if (full) begin
                // fewest loads, ties go to the highest index
                least = loads[0];
                victim = 0;
                for (int x = 1; x < 128; x++) begin
                    if (loads[x] <= least) begin
                        least = loads[x];
                        victim = x;
                    end
                end
                frame = 7'(victim);
                drop_frame(frame, map_lim, tlb_lim);
                n_evict++;
            end
            map_tag[map_count % 256] = page;
            map_frame[map_count % 256] = frame;
            map_count = (map_count + 1) & 9'h1ff;
            tlb_tag[tlb_count % 16] = page;
            tlb_frame[tlb_count % 16] = frame;
            tlb_count = tlb_count + 1;
            if (loads[frame] != 16'hffff) loads[frame]++;
            fault = 1;
        end
        if (hit) n_hit++;
        else if (fault) n_fault++;
        else n_walk++;
        exp_paddr.push_back({frame, va[7:0]});
        exp_hit.push_back(hit);
        exp_fault.push_back(fault);
    endfunction

    function void check_result(logic [14:0] paddr, logic hit, logic fault);
        logic [14:0] e_paddr;
        bit          e_hit, e_fault;
        if (exp_paddr.size() == 0) begin
            $error("unexpected result transfer: physical_address %h", paddr);
            errors++;
            return;
        end
        e_paddr = exp_paddr.pop_front();
        e_hit = exp_hit.pop_front();
        e_fault = exp_fault.pop_front();
        if (paddr !== e_paddr) begin
            $error("physical_address expected %h actual %h", e_paddr, paddr);
            errors++;
        end
        if (hit !== e_hit) begin
            $error("tlb_hit expected %0d actual %0d", e_hit, hit);
            errors++;
        end
        if (fault !== e_fault) begin
            $error("page_fault expected %0d actual %0d", e_fault, fault);
            errors++;
        end
    endfunction
endclass

module tb;
    import tlbpt_pkg::*;

    localparam int IDLE_PCT   = 35;
    localparam int WATCHDOG   = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [VADDR_W-1:0] i_virtual_address;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [PADDR_W-1:0] o_physical_address;
    logic               o_tlb_hit;
    logic               o_page_fault;

    xlate_scoreboard sb;
    bit              calm;      // no idling on either side
    int              idle_cycles;
    int              n_sent;

    tlb_page_table_translator i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_virtual_address (i_virtual_address),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_physical_address(o_physical_address),
        .o_tlb_hit         (o_tlb_hit),
        .o_page_fault      (o_page_fault)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        sb = new();
        sb.clear_state();
    end

    // result side: random stall, check each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_physical_address, o_tlb_hit, o_page_fault);
            i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_address(logic [15:0] va);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_virtual_address <= va;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_address(va);
        n_sent++;
    endtask

    task automatic send_random(int count, int span);
        logic [15:0] va;
        for (int k = 0; k < count; k++) begin
            va = 16'($urandom);
            // mostly a working set to get repeat hits, sometimes anywhere
            if ($urandom_range(99) < 75) va[15:8] = 8'($urandom_range(span - 1));
            send_address(va);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_virtual_address = '0;
        i_out_stall = 1'b0;
        calm = 1'b0;
        n_sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, tlb hit, table walk, fault
        send_address(16'h0000);
        send_address(16'hffff);
        send_address(16'h00ff);
        send_address(16'hff00);
        send_address(16'haa55);
        send_address(16'h55aa);
        for (int p = 1; p <= 16; p++) send_address({p[7:0], 8'h80});
        send_address(16'h0001);   // pushed out of the tlb, found by the walk
        send_address(16'h1011);   // still in the tlb

        // random: fill every frame, then eviction pressure on a wide page range
        send_random(100, 40);
        calm = 1'b1;
        send_random(60, 160);
        calm = 1'b0;
        send_random(270, 256);
        i_in_valid <= 1'b0;

        while (sb.exp_paddr.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("sent %0d addresses: %0d tlb hits, %0d table hits, %0d faults",
                 n_sent, sb.n_hit, sb.n_walk, sb.n_fault);
        $display("%0d faults needed an eviction; %0d mismatches",
                 sb.n_evict, sb.errors);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

[tlb_page_table_translator.f]
design/tlbpt_pkg.sv
design/tlbpt_spram.sv
design/tlb_page_table_translator.sv
test/tb.sv
